/* sv/sitda_pkg.sv */
// Shared types and constants for the signed integer to decimal ASCII block.
// Used by sitda_bcd_cell and signed_int_to_decimal_ascii; no dependencies.
package sitda_pkg;

	localparam int VALUE_W     = 32;
	localparam int CHAR_W      = 8;
	localparam int NIB_W       = 4;
	localparam int STEP_W      = $clog2(VALUE_W);
	localparam int DIGIT_COUNT = 10;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

	// Per-cycle command broadcast to every digit cell.
	typedef struct packed {
		logic clear;   // zero the digit
		logic dabble;  // add-3 correct, then shift one bit in from below
		logic move;    // take the whole digit from the lower neighbor
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

endpackage

/* sv/sitda_bcd_cell.sv */
// One BCD digit cell of the double dabble chain.
// Depends on sitda_pkg for the cell command struct and nibble width.
module sitda_bcd_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sitda_pkg::cell_ctl_t       ctl,
	input  logic                       bit_in,
	input  logic [sitda_pkg::NIB_W-1:0] nib_in,
	output logic [sitda_pkg::NIB_W-1:0] digit,
	output logic                       bit_out
);

	logic [sitda_pkg::NIB_W-1:0] digit_q;
	logic [sitda_pkg::NIB_W-1:0] corrected;

	// Add 3 to digits of 5 or more so the shift carries into the next decade.
	assign corrected = (digit_q >= sitda_pkg::NIB_W'(5)) ?
		digit_q + sitda_pkg::NIB_W'(3) : digit_q;
	assign bit_out   = corrected[sitda_pkg::NIB_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.dabble) begin
			digit_q <= {corrected[sitda_pkg::NIB_W-2:0], bit_in};
		end else if (ctl.move) begin
			digit_q <= nib_in;
		end
	end

endmodule

/* sv/signed_int_to_decimal_ascii.sv */
// Top level: signed 32-bit integer to decimal ASCII, one character per word.
// Depends on sitda_pkg and a chain of sitda_bcd_cell digit cells.
//
// Usage:
//   Input channel (value, in_valid, in_ready) takes one two's complement
//   integer per word. Output channel (character, last, out_valid, out_ready)
//   gives its decimal text, most significant character first: a leading '-'
//   for negative values, no leading zeros, and last high on the final digit.
//   Timing: after acceptance, bit-serial double dabble runs through the
//   digit cell chain, one shift per cycle. Emission then shifts the digits
//   up the chain one per cycle while the receiver does not stall; leading
//   zeros are dropped at one per cycle. in_ready is high only while the
//   block is idle, so a new integer is not taken until the final digit of
//   the previous one has been emitted.
//   The output register holds a character while out_ready is low; the chain
//   holds its digits until the character is taken.
//   Reset (arst_n low) clears the state machine, the output register and
//   all digit cells; in_ready is high as soon as the state machine is idle.
module signed_int_to_decimal_ascii #(
	parameter int DIGIT_COUNT = sitda_pkg::DIGIT_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [sitda_pkg::VALUE_W-1:0] value,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic [sitda_pkg::CHAR_W-1:0]  character,
	output logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready
);

	localparam int REM_W = $clog2(DIGIT_COUNT + 1);

	sitda_pkg::state_t                   state_q;
	logic [sitda_pkg::VALUE_W-1:0]       binary_shift_q;
	logic [sitda_pkg::STEP_W-1:0]        step_q;
	logic                                neg_q;
	logic                                sign_pend_q;
	logic                                started_q;
	logic [REM_W-1:0]                    rem_q;
	logic                                out_valid_q;
	logic [sitda_pkg::CHAR_W-1:0]        character_q;
	logic                                last_q;

	logic                                in_acc;
	logic                                out_free;
	logic                                skip;
	logic                                emit_sign;
	logic                                emit_digit;
	logic [sitda_pkg::VALUE_W-1:0]       magnitude;
	logic [sitda_pkg::NIB_W-1:0]         top;
	sitda_pkg::cell_ctl_t                ctl;

	logic [sitda_pkg::NIB_W-1:0]         digit [DIGIT_COUNT];
	logic                                carry [DIGIT_COUNT];

	assign in_ready  = (state_q == sitda_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign magnitude = value[sitda_pkg::VALUE_W-1] ?
		($unsigned(~value) + sitda_pkg::VALUE_W'(1)) : $unsigned(value);
	assign top       = digit[DIGIT_COUNT-1];

	// Drop a leading zero, but always keep the units digit.
	assign skip       = (state_q == sitda_pkg::ST_EMIT) && !started_q &&
		(top == '0) && (rem_q != REM_W'(1));
	assign emit_sign  = (state_q == sitda_pkg::ST_EMIT) && out_free && sign_pend_q;
	assign emit_digit = (state_q == sitda_pkg::ST_EMIT) && out_free && !sign_pend_q &&
		!skip;

	assign ctl.clear  = in_acc;
	assign ctl.dabble = (state_q == sitda_pkg::ST_CONV);
	assign ctl.move   = skip || emit_digit;

	for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_cell
		logic                        bit_in;
		logic [sitda_pkg::NIB_W-1:0] nib_in;
		if (i == 0) begin : g_low
			assign bit_in = binary_shift_q[sitda_pkg::VALUE_W-1];
			assign nib_in = '0;
		end else begin : g_up
			assign bit_in = carry[i-1];
			assign nib_in = digit[i-1];
		end
		sitda_bcd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.bit_in  (bit_in),
			.nib_in  (nib_in),
			.digit   (digit[i]),
			.bit_out (carry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= sitda_pkg::ST_IDLE;
			binary_shift_q <= '0;
			step_q         <= '0;
			neg_q          <= 1'b0;
			sign_pend_q    <= 1'b0;
			started_q      <= 1'b0;
			rem_q          <= '0;
		end else begin
			unique case (state_q)
				sitda_pkg::ST_IDLE: begin
					if (in_acc) begin
						binary_shift_q <= magnitude;
						neg_q          <= value[sitda_pkg::VALUE_W-1];
						step_q         <= '0;
						state_q        <= sitda_pkg::ST_CONV;
					end
				end
				sitda_pkg::ST_CONV: begin
					binary_shift_q <= {binary_shift_q[sitda_pkg::VALUE_W-2:0], 1'b0};
					step_q         <= step_q + sitda_pkg::STEP_W'(1);
					if (step_q == sitda_pkg::STEP_W'(sitda_pkg::VALUE_W - 1)) begin
						sign_pend_q <= neg_q;
						started_q   <= 1'b0;
						rem_q       <= REM_W'(DIGIT_COUNT);
						state_q     <= sitda_pkg::ST_EMIT;
					end
				end
				sitda_pkg::ST_EMIT: begin
					if (emit_sign) begin
						sign_pend_q <= 1'b0;
					end
					if (skip) begin
						rem_q <= rem_q - REM_W'(1);
					end else if (emit_digit) begin
						rem_q     <= rem_q - REM_W'(1);
						started_q <= 1'b1;
						if (rem_q == REM_W'(1)) begin
							state_q <= sitda_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= sitda_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Output register: load a word when free, hold it while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_sign || emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			character_q <= '0;
			last_q      <= 1'b0;
		end else if (emit_sign) begin
			character_q <= sitda_pkg::ASCII_MINUS;
			last_q      <= 1'b0;
		end else if (emit_digit) begin
			character_q <= sitda_pkg::ASCII_ZERO + sitda_pkg::CHAR_W'(top);
			last_q      <= (rem_q == REM_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;

	a_acc_to_conv: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == sitda_pkg::ST_CONV))
		else $error("accepted word did not start a conversion");

	a_sign_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		sign_pend_q |-> (state_q == sitda_pkg::ST_EMIT))
		else $error("pending sign outside emission");

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sitda_pkg::ST_EMIT) |-> (rem_q != '0))
		else $error("emission with no digits left");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_digit && (rem_q == REM_W'(1))) |=> (state_q == sitda_pkg::ST_IDLE))
		else $error("final digit did not end the run");

endmodule

/* tb/signed_int_to_decimal_ascii_tb.sv */
// Testbench for signed_int_to_decimal_ascii: drives integers, predicts the decimal text
// with its own double dabble, and checks every character word and its last flag in order.
// Depends on sitda_pkg and the signed_int_to_decimal_ascii RTL.
module signed_int_to_decimal_ascii_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [sitda_pkg::CHAR_W-1:0] character;
		logic                         last;
	} text_char_t;

	logic                                 clk;
	logic                                 arst_n;
	logic signed [sitda_pkg::VALUE_W-1:0] value;
	logic                                 in_valid;
	logic                                 in_ready;
	logic [sitda_pkg::CHAR_W-1:0]         character;
	logic                                 last;
	logic                                 out_valid;
	logic                                 out_ready;

	text_char_t pending_text[$];
	int         mismatches;
	bit         calm;

	signed_int_to_decimal_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.character (character),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Convert the magnitude bit-serially to BCD, then queue the text MSD first.
	task automatic queue_decimal_text(input logic [sitda_pkg::VALUE_W-1:0] v);
		logic [sitda_pkg::VALUE_W-1:0]                     mag;
		logic [sitda_pkg::DIGIT_COUNT*sitda_pkg::NIB_W-1:0] bcd;
		int                                                top;
		text_char_t                                        ch;
		mag = v[sitda_pkg::VALUE_W-1] ? (~v + 1'b1) : v;
		bcd = '0;
		for (int s = 0; s < sitda_pkg::VALUE_W; s++) begin
			for (int d = 0; d < sitda_pkg::DIGIT_COUNT; d++) begin
				if (bcd[d*sitda_pkg::NIB_W +: sitda_pkg::NIB_W] >= 4'd5)
					bcd[d*sitda_pkg::NIB_W +: sitda_pkg::NIB_W] =
						bcd[d*sitda_pkg::NIB_W +: sitda_pkg::NIB_W] + 4'd3;
			end
			bcd = {bcd[sitda_pkg::DIGIT_COUNT*sitda_pkg::NIB_W-2:0],
				mag[sitda_pkg::VALUE_W-1]};
			mag = mag << 1;
		end
		top = 0;
		for (int d = 0; d < sitda_pkg::DIGIT_COUNT; d++) begin
			if (bcd[d*sitda_pkg::NIB_W +: sitda_pkg::NIB_W] != 4'd0)
				top = d;
		end
		if (v[sitda_pkg::VALUE_W-1]) begin
			ch.character = sitda_pkg::ASCII_MINUS;
			ch.last      = 1'b0;
			pending_text.push_back(ch);
		end
		for (int d = top; d >= 0; d--) begin
			ch.character = sitda_pkg::ASCII_ZERO +
				sitda_pkg::CHAR_W'(bcd[d*sitda_pkg::NIB_W +: sitda_pkg::NIB_W]);
			ch.last      = (d == 0);
			pending_text.push_back(ch);
		end
	endtask

	task automatic report_mismatch(input string what);
		if (mismatches < 10)
			$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Compare each accepted character word with the oldest pending one.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_text.size() == 0) begin
				report_mismatch($sformatf("unexpected word character=%02h last=%b",
					character, last));
			end else begin
				want = pending_text.pop_front();
				if (character !== want.character || last !== want.last)
					report_mismatch($sformatf("expected character=%02h last=%b, got %02h %b",
						want.character, want.last, character, last));
			end
		end
	end

	// Receiver: stall about one cycle in five unless in a calm stretch.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);
		end
	end

	task automatic send_value(input logic [sitda_pkg::VALUE_W-1:0] v);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		value    <= v;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		queue_decimal_text(v);
	endtask

	// Drop valid so the word just taken is not offered again, then wait.
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		logic [sitda_pkg::VALUE_W-1:0] picks[$];
		picks = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd2147483647,
			32'h8000_0000, 32'h8000_0001, 32'd1000000000, -32'sd1000000000,
			32'd999999999, -32'sd999999999, 32'd99999, 32'd100000, 32'd5, 32'd55555,
			32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, -32'sd7, 32'd4294967, 32'd1234567890};
		foreach (picks[i])
			send_value(picks[i]);
	endtask

	task automatic test_random(input int count);
		longint                        pow10;
		longint                        mag;
		int                            kind;
		logic [sitda_pkg::VALUE_W-1:0] v;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			if (kind <= 3) begin
				v = $urandom;
			end else if (kind <= 7) begin
				pow10 = 1;
				repeat ($urandom_range(1, 10)) pow10 = pow10 * 10;
				mag = longint'({$urandom}) % pow10;
				v = sitda_pkg::VALUE_W'($urandom_range(0, 1) ? -mag : mag);
			end else if (kind == 8) begin
				// land on a digit-count boundary
				pow10 = 1;
				repeat ($urandom_range(1, 9)) pow10 = pow10 * 10;
				mag = pow10 - longint'($urandom_range(0, 1));
				v = sitda_pkg::VALUE_W'($urandom_range(0, 1) ? -mag : mag);
			end else begin
				v = sitda_pkg::VALUE_W'($urandom_range(0, 40) - 20);
			end
			send_value(v);
		end
	endtask

	task automatic test_back_to_back();
		calm = 1'b1;
		test_random(30);
		calm = 1'b0;
	endtask

	task automatic test_drain_pause();
		test_random(5);
		wait_for_drain();
		test_random(5);
	endtask

	initial begin
		mismatches = 0;
		calm       = 1'b0;
		arst_n     = 1'b0;
		value      = '0;
		in_valid   = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(50);
		test_back_to_back();
		test_drain_pause();
		test_random(60);

		wait_for_drain();
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending_text.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("simulation failed");
		$finish;
	end

endmodule
